/* src/rdf_pkg.sv */
// Package for the radix digit formatter: shared widths, reset values,
// register codes, controller states and the command/status structs.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package rdf_pkg;

  localparam int CHAR_W      = 8;
  localparam int ALPHA_CHARS = 40;
  localparam int ALPHA_WORDS = 5;
  localparam int ALPHA_W     = ALPHA_CHARS * CHAR_W;
  localparam int CHAR_IDX_W  = 6;
  localparam int SIZE_W      = 6;
  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 7;
  localparam int REG_W       = 64;
  localparam int ADDR_W      = 6;

  localparam logic [SIZE_W-1:0] MIN_BASE      = 6'd2;
  localparam logic [SIZE_W-1:0] BASE_SIZE_RST = 6'd10;
  localparam logic [REG_W-1:0]  ALPHA0_RST    = 64'h3736_3534_3332_3130;
  localparam logic [REG_W-1:0]  ALPHA1_RST    = 64'h0000_0000_0000_3938;
  localparam logic [REG_W-1:0]  ALPHA_ZERO    = 64'h0;

  localparam logic [CHAR_W-1:0] ASCII_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] ASCII_0    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_9    = 8'h39;

  // Register index, taken from byte address bits [5:3].
  typedef enum logic [2:0] {
    REG_BASE_SIZE = 3'd0,
    REG_ALPHA0    = 3'd1,
    REG_ALPHA1    = 3'd2,
    REG_ALPHA2    = 3'd3,
    REG_ALPHA3    = 3'd4,
    REG_ALPHA4    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RD,
    ST_LD,
    ST_WAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_value;
    logic chk_step;
    logic div_step;
    logic rd_issue;
    logic rd_next;
    logic out_load_digit;
    logic out_load_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_bad;
    logic chk_fail;
    logic chk_last;
    logic div_last;
    logic quot_zero;
    logic out_last;
  } sts_t;

  // True for ASCII letters and decimal digits.
  function automatic logic char_class_ok(input logic [CHAR_W-1:0] c);
    return ((c >= ASCII_UP_A) && (c <= ASCII_UP_Z)) ||
           ((c >= ASCII_LO_A) && (c <= ASCII_LO_Z)) ||
           ((c >= ASCII_0) && (c <= ASCII_9));
  endfunction

endpackage

`default_nettype wire

/* src/rdf_in_if.sv */
// Input channel of the radix digit formatter: valid/ready plus the value.
// Depends on rdf_pkg for the field width.
`default_nettype none

interface rdf_in_if import rdf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

/* src/rdf_out_if.sv */
// Result channel of the radix digit formatter: valid/ready plus one character.
// Depends on rdf_pkg for the field widths.
`default_nettype none

interface rdf_out_if import rdf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  out_char;
  logic               char_valid;
  logic               is_last;
  logic [COUNT_W-1:0] char_count;
  logic               base_ok;

  modport source (output valid, output out_char, output char_valid, output is_last,
                  output char_count, output base_ok, input ready);
  modport sink (input valid, input out_char, input char_valid, input is_last,
                input char_count, input base_ok, output ready);
endinterface

`default_nettype wire

/* src/rdf_regs.sv */
// APB-style register file: base size and the five alphabet words.
// Depends on rdf_pkg for register codes and reset values.
`default_nettype none

module rdf_regs import rdf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [REG_W-1:0]      pwdata,
  output logic      [REG_W-1:0]      prdata,
  output logic                       pready,
  output logic      [SIZE_W-1:0]     base_size,
  output logic      [ALPHA_W-1:0]    alphabet
);

  logic [SIZE_W-1:0] base_size_r;
  logic [REG_W-1:0]  alpha_r [ALPHA_WORDS];
  logic              wr_en;
  cfg_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[5:3]);

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= BASE_SIZE_RST;
      alpha_r[0]  <= ALPHA0_RST;
      alpha_r[1]  <= ALPHA1_RST;
      alpha_r[2]  <= ALPHA_ZERO;
      alpha_r[3]  <= ALPHA_ZERO;
      alpha_r[4]  <= ALPHA_ZERO;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE_SIZE: base_size_r <= pwdata[SIZE_W-1:0];
        REG_ALPHA0:    alpha_r[0]  <= pwdata;
        REG_ALPHA1:    alpha_r[1]  <= pwdata;
        REG_ALPHA2:    alpha_r[2]  <= pwdata;
        REG_ALPHA3:    alpha_r[3]  <= pwdata;
        REG_ALPHA4:    alpha_r[4]  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (reg_sel)
      REG_BASE_SIZE: prdata = {{(REG_W-SIZE_W){1'b0}}, base_size_r};
      REG_ALPHA0:    prdata = alpha_r[0];
      REG_ALPHA1:    prdata = alpha_r[1];
      REG_ALPHA2:    prdata = alpha_r[2];
      REG_ALPHA3:    prdata = alpha_r[3];
      REG_ALPHA4:    prdata = alpha_r[4];
      default:       prdata = '0;
    endcase
  end

  assign base_size = base_size_r;
  assign alphabet  = {alpha_r[4], alpha_r[3], alpha_r[2], alpha_r[1], alpha_r[0]};

endmodule

`default_nettype wire

/* src/rdf_ctrl.sv */
// Controller of the radix digit formatter: sequences check, division,
// digit readback and the result transfer. Depends on rdf_pkg.
`default_nettype none

module rdf_ctrl import rdf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_value = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.size_bad || sts.chk_fail) begin
          cmd.out_load_err = 1'b1;
          state_nxt        = ST_WAIT;
        end else if (sts.chk_last) begin
          state_nxt = ST_DIV;
        end else begin
          cmd.chk_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.quot_zero) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LD;
      end
      ST_LD: begin
        cmd.out_load_digit = 1'b1;
        state_nxt          = ST_WAIT;
      end
      ST_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/rdf_dp.sv */
// Datapath of the radix digit formatter: base checker, bit-serial divider,
// digit memory and result registers. Depends on rdf_pkg.
`default_nettype none

module rdf_dp import rdf_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_BASE   = 40
) (
  input  wire logic               clk,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic [SIZE_W-1:0]  base_size,
  input  wire logic [ALPHA_W-1:0] alphabet,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic [CHAR_W-1:0]       out_char,
  output logic                    char_valid,
  output logic                    is_last,
  output logic [COUNT_W-1:0]      char_count,
  output logic                    base_ok
);

  localparam int IDX_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [CHAR_W-1:0]     chars [ALPHA_CHARS];
  logic [VALUE_BITS-1:0] val_r;
  logic [SIZE_W-1:0]     rem_r;
  logic [IDX_W-1:0]      bit_cnt_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CHAR_IDX_W-1:0] chk_idx_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [SIZE_W-1:0]     rd_data_r;
  logic [SIZE_W-1:0]     dig_mem [VALUE_BITS];
  logic [CHAR_W-1:0]     out_char_r;
  logic                  char_valid_r;
  logic                  is_last_r;
  logic [COUNT_W-1:0]    char_count_r;
  logic                  base_ok_r;

  logic [CHAR_W-1:0]     cur_char;
  logic [ALPHA_CHARS-1:0] dup;
  logic [SIZE_W:0]       rem_sh;
  logic                  rem_ge;
  logic [SIZE_W-1:0]     rem_nxt;
  logic [VALUE_BITS-1:0] val_nxt;
  logic                  div_last;

  always_comb begin
    for (int k = 0; k < ALPHA_CHARS; k++) begin
      chars[k] = alphabet[k*CHAR_W +: CHAR_W];
    end
  end

  // Base check: one alphabet character per cycle, compared against all later ones below base_size.
  assign cur_char = chars[chk_idx_r];
  always_comb begin
    for (int j = 0; j < ALPHA_CHARS; j++) begin
      dup[j] = (CHAR_IDX_W'(j) > chk_idx_r) && (CHAR_IDX_W'(j) < base_size) &&
               (chars[j] == cur_char);
    end
  end

  assign sts.size_bad = (base_size < MIN_BASE) || (base_size > SIZE_W'(MAX_BASE));
  assign sts.chk_fail = !char_class_ok(cur_char) || (|dup);
  assign sts.chk_last = (chk_idx_r == base_size - MIN_BASE + SIZE_W'(1));

  // Restoring divider step: one quotient bit per cycle.
  assign rem_sh   = {rem_r, val_r[VALUE_BITS-1]};
  assign rem_ge   = (rem_sh >= {1'b0, base_size});
  assign rem_nxt  = rem_ge ? SIZE_W'(rem_sh - {1'b0, base_size}) : rem_sh[SIZE_W-1:0];
  assign val_nxt  = {val_r[VALUE_BITS-2:0], rem_ge};
  assign div_last = (bit_cnt_r == IDX_W'(VALUE_BITS - 1));

  assign sts.div_last  = div_last;
  assign sts.quot_zero = (val_nxt == '0);
  assign sts.out_last  = is_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_value) begin
      val_r     <= in_value[VALUE_BITS-1:0];
      rem_r     <= '0;
      bit_cnt_r <= '0;
      cnt_r     <= '0;
      chk_idx_r <= '0;
    end else if (cmd.chk_step) begin
      chk_idx_r <= chk_idx_r + CHAR_IDX_W'(1);
    end else if (cmd.div_step) begin
      val_r <= val_nxt;
      if (div_last) begin
        // Digit complete: restart the remainder for the next digit.
        rem_r     <= '0;
        bit_cnt_r <= '0;
        cnt_r     <= cnt_r + CNT_W'(1);
        rd_idx_r  <= cnt_r[IDX_W-1:0];
      end else begin
        rem_r     <= rem_nxt;
        bit_cnt_r <= bit_cnt_r + IDX_W'(1);
      end
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r - IDX_W'(1);
    end
  end

  // Digit memory, least significant digit at address zero.
  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last) begin
      dig_mem[cnt_r[IDX_W-1:0]] <= rem_nxt;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= dig_mem[rd_idx_r];
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load_err) begin
      out_char_r   <= '0;
      char_valid_r <= 1'b0;
      is_last_r    <= 1'b1;
      char_count_r <= '0;
      base_ok_r    <= 1'b0;
    end else if (cmd.out_load_digit) begin
      out_char_r   <= chars[rd_data_r];
      char_valid_r <= 1'b1;
      is_last_r    <= (rd_idx_r == '0);
      char_count_r <= (rd_idx_r == '0) ? COUNT_W'(cnt_r) : '0;
      base_ok_r    <= 1'b1;
    end
  end

  assign out_char   = out_char_r;
  assign char_valid = char_valid_r;
  assign is_last    = is_last_r;
  assign char_count = char_count_r;
  assign base_ok    = base_ok_r;

endmodule

`default_nettype wire

/* src/radix_digit_formatter.sv */
// Radix digit formatter: writes an unsigned value as alphabet characters, MSD first.
// Sequence: a base check of one alphabet character at a time up to base_size, then the
// bit-serial divider for each digit, then readback, load and output wait per emitted character.
// Throughput: one item at a time; a new value is taken only in the idle state, once the
// last character of the previous value has been accepted.
// Reset (synchronous, rst_n low) returns to idle, base_size 10, alphabet "0123456789".
// Depends on rdf_pkg, rdf_in_if, rdf_out_if, rdf_regs, rdf_ctrl and rdf_dp.
`default_nettype none

module radix_digit_formatter import rdf_pkg::*; #(
  parameter int MAX_BASE   = 40,
  parameter int VALUE_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rdf_in_if.sink                 in_ch,
  rdf_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output logic                   pready
);

  logic [SIZE_W-1:0]  base_size;
  logic [ALPHA_W-1:0] alphabet;
  cmd_t               cmd;
  sts_t               sts;

  rdf_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .base_size (base_size),
    .alphabet  (alphabet)
  );

  rdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_BASE   (MAX_BASE)
  ) u_dp (
    .clk        (clk),
    .in_value   (in_ch.value),
    .base_size  (base_size),
    .alphabet   (alphabet),
    .cmd        (cmd),
    .sts        (sts),
    .out_char   (out_ch.out_char),
    .char_valid (out_ch.char_valid),
    .is_last    (out_ch.is_last),
    .char_count (out_ch.char_count),
    .base_ok    (out_ch.base_ok)
  );

endmodule

`default_nettype wire

/* dv/radix_digit_formatter_checker.sv */
// Scoreboard for the radix digit formatter: tracks register writes, predicts the
// character transfers for every accepted value and compares them in order.
// Depends on rdf_pkg, rdf_in_if and rdf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_formatter_checker import rdf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rdf_in_if                      in_ch,
  rdf_out_if                     out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  input  wire logic              pready,
  output int                     mismatches,
  output int                     outstanding,
  output int                     values_seen,
  output int                     chars_seen,
  output int                     bad_bases
);

  localparam int MAX_PRINTED = 40;
  localparam int MAX_DIGITS  = 64;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               char_valid;
    logic               is_last;
    logic [COUNT_W-1:0] count;
    logic               base_ok;
  } char_result_t;

  // Local copy of the radix and the alphabet registers.
  logic [SIZE_W-1:0] radix_q;
  logic [REG_W-1:0]  alphabet_q [ALPHA_WORDS];

  char_result_t      pending_chars [$];
  char_result_t      want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    values_seen = 0;
    chars_seen  = 0;
    bad_bases   = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic logic [CHAR_W-1:0] alphabet_char(input int k);
    return alphabet_q[k / 8][(k % 8) * CHAR_W +: CHAR_W];
  endfunction

  function automatic bit is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  // The base passes when the size is in range and the characters in use are
  // letters or digits with no repeats; bytes past the size do not matter.
  function automatic bit alphabet_valid();
    int n;
    n = int'(radix_q);
    if (n < 2 || n > ALPHA_CHARS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!is_alnum(alphabet_char(i))) return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (alphabet_char(i) == alphabet_char(j)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue up the characters for one value, most significant digit first.
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [CHAR_W-1:0]  digit_chars [MAX_DIGITS];
    int                 n;
    char_result_t       r;
    values_seen++;
    if (!alphabet_valid()) begin
      r = '{ch: '0, char_valid: 1'b0, is_last: 1'b1, count: '0, base_ok: 1'b0};
      pending_chars.push_back(r);
      bad_bases++;
      return;
    end
    rest = v;
    n    = 0;
    do begin
      digit_chars[n] = alphabet_char(int'(rest % VALUE_W'(radix_q)));
      rest = rest / VALUE_W'(radix_q);
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      r.ch         = digit_chars[n - 1 - k];
      r.char_valid = 1'b1;
      r.is_last    = (k == n - 1);
      r.count      = (k == n - 1) ? COUNT_W'(n) : '0;
      r.base_ok    = 1'b1;
      pending_chars.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      radix_q       = BASE_SIZE_RST;
      alphabet_q[0] = ALPHA0_RST;
      alphabet_q[1] = ALPHA1_RST;
      alphabet_q[2] = ALPHA_ZERO;
      alphabet_q[3] = ALPHA_ZERO;
      alphabet_q[4] = ALPHA_ZERO;
      pending_chars.delete();
      outstanding <= 0;
    end else begin
      // Register write completes on the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_BASE_SIZE: radix_q = pwdata[SIZE_W-1:0];
          REG_ALPHA0:    alphabet_q[0] = pwdata;
          REG_ALPHA1:    alphabet_q[1] = pwdata;
          REG_ALPHA2:    alphabet_q[2] = pwdata;
          REG_ALPHA3:    alphabet_q[3] = pwdata;
          REG_ALPHA4:    alphabet_q[4] = pwdata;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
      end

      // Each character transfer is matched against the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("transfer with nothing predicted, char 0x%02h",
                                    out_ch.out_char));
        end else begin
          want = pending_chars.pop_front();
          if (out_ch.out_char !== want.ch)
            report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
                                      out_ch.out_char, want.ch));
          if (out_ch.char_valid !== want.char_valid)
            report_mismatch($sformatf("char_valid %b, predicted %b",
                                      out_ch.char_valid, want.char_valid));
          if (out_ch.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %b, predicted %b",
                                      out_ch.is_last, want.is_last));
          if (out_ch.char_count !== want.count)
            report_mismatch($sformatf("char_count %0d, predicted %0d",
                                      out_ch.char_count, want.count));
          if (out_ch.base_ok !== want.base_ok)
            report_mismatch($sformatf("base_ok %b, predicted %b",
                                      out_ch.base_ok, want.base_ok));
        end
      end
      outstanding <= pending_chars.size();
    end
  end

endmodule

`default_nettype wire

/* dv/radix_digit_formatter_tb.sv */
// Top of the radix digit formatter testbench: clock, reset, register writes,
// value stimulus with random idling on both channels, and the verdict.
// Depends on rdf_pkg, rdf_in_if, rdf_out_if, the block and its checker.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_formatter_tb;
  import rdf_pkg::*;

  // Worst case is a value at radix 2; the limit leaves room for the slowest run
  // with stalls and the long hold-off.
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Longer than the slowest conversion, so a finished result is always held back.
  localparam int HOLD_CYCLES  = 10_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int BATCH_ITEMS  = 10;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  wire  [REG_W-1:0]  prdata;
  wire               pready;

  int                cycles;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                settings;
  logic              hold_on;
  event              long_hold;

  int                mismatches;
  int                outstanding;
  int                values_seen;
  int                chars_seen;
  int                bad_bases;

  logic [CHAR_W-1:0] alpha_buf [ALPHA_CHARS];
  string             legal_chars =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  logic [CHAR_W-1:0] bad_chars [9] =
    '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h20};

  rdf_in_if  in_ch ();
  rdf_out_if out_ch ();

  radix_digit_formatter #(
    .MAX_BASE   (40),
    .VALUE_BITS (64)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  radix_digit_formatter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .values_seen (values_seen),
    .chars_seen  (chars_seen),
    .bad_bases   (bad_bases)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Runaway guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transfers still predicted", cycles, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random back-pressure, or ready held low during a long hold-off.
  always @(posedge clk) begin
    out_ch.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // The long hold-off counts its own cycles.
  initial begin
    forever begin
      @(long_hold);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_alphabet();
    logic [REG_W-1:0] word;
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      for (int b = 0; b < 8; b++) word[b * CHAR_W +: CHAR_W] = alpha_buf[w * 8 + b];
      write_reg(3'(REG_ALPHA0 + w), word);
    end
  endtask

  // The upper bits of the size write are always junk; only six bits count.
  task automatic set_radix(input int n);
    write_reg(REG_BASE_SIZE, {$urandom, 26'($urandom), 6'(n)});
    settings++;
  endtask

  task automatic load_string(input string s);
    for (int k = 0; k < ALPHA_CHARS; k++) alpha_buf[k] = (k < s.len()) ? s[k] : 8'h00;
  endtask

  // Offer one value and hold it until the block takes it.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every predicted character has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return VALUE_W'($urandom_range(50));
      1:       return '1;
      2, 3, 4: return {$urandom, $urandom};
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  // Shuffled letters and digits for the first n characters, junk beyond, and
  // now and then one bad or repeated character among those in use.
  task automatic build_random_alphabet(input int n, input bit spoil);
    int pick [62];
    int j;
    int tmp;
    int a;
    for (int i = 0; i < 62; i++) pick[i] = i;
    for (int i = 61; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = pick[i];
      pick[i] = pick[j];
      pick[j] = tmp;
    end
    for (int k = 0; k < ALPHA_CHARS; k++) begin
      alpha_buf[k] = (k < n) ? legal_chars[pick[k]] : CHAR_W'($urandom);
    end
    if (spoil) begin
      a = $urandom_range(n - 1);
      if ($urandom_range(1)) begin
        alpha_buf[a] = bad_chars[$urandom_range(8)];
      end else begin
        j = (a + 1 + $urandom_range(n - 2)) % n;
        alpha_buf[j] = alpha_buf[a];
      end
    end
  endtask

  // Mostly good bases, many with small radixes, some at the top, a few broken.
  task automatic random_setting();
    int n;
    bit spoil;
    case ($urandom_range(19))
      0: begin
        case ($urandom_range(2))
          0:       n = 0;
          1:       n = 1;
          default: n = $urandom_range(41, 63);
        endcase
      end
      1, 2, 3, 4, 5, 6: n = $urandom_range(2, 4);
      7, 8:             n = ALPHA_CHARS;
      default:          n = $urandom_range(5, 39);
    endcase
    spoil = (n >= 2 && n <= ALPHA_CHARS && $urandom_range(9) == 0);
    build_random_alphabet((n >= 2 && n <= ALPHA_CHARS) ? n : 2, spoil);
    write_alphabet();
    set_radix(n);
  endtask

  task automatic random_batches(input int count);
    for (int s = 0; s < count; s++) begin
      wait_drained();
      random_setting();
      for (int i = 0; i < BATCH_ITEMS; i++) send_value(random_value());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    hold_on       = 1'b0;
    settings      = 1;
    send_idle_pct = 19;
    recv_idle_pct = 86;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decimal out of reset: zero, small values, the radix itself, extremes.
    send_value('0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);

    // Binary gives the longest strings.
    wait_drained();
    set_radix(2);
    send_value('1);
    send_value('0);
    send_value(64'd1);

    // Largest radix with a full alphabet in every word.
    wait_drained();
    load_string("ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789wxyz");
    write_alphabet();
    set_radix(ALPHA_CHARS);
    send_value('1);
    send_value(64'd39);
    send_value(64'd40);

    // Sizes that fail the base check.
    wait_drained();
    set_radix(0);
    send_value(random_value());
    wait_drained();
    set_radix(1);
    send_value(random_value());
    wait_drained();
    set_radix(ALPHA_CHARS + 1);
    send_value(random_value());
    wait_drained();
    set_radix(63);
    send_value(random_value());

    // A space among the characters in use.
    wait_drained();
    load_string("0123 56789AB");
    write_alphabet();
    set_radix(12);
    send_value(random_value());

    // A repeated character.
    wait_drained();
    load_string("01231");
    write_alphabet();
    set_radix(5);
    send_value(random_value());

    // Bad and repeated bytes past the size are ignored.
    wait_drained();
    load_string("abca!");
    write_alphabet();
    set_radix(3);
    send_value('1);

    // Writes past the register list leave the base-3 setting alone.
    wait_drained();
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_value(64'd12345);

    // Random phases: slow receiver, then slow sender, then no idling.
    random_batches(3);
    wait_drained();
    send_idle_pct = 86;
    recv_idle_pct = 19;
    random_batches(3);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_batches(2);

    // Receiver holds off while the sender keeps offering.
    wait_drained();
    random_setting();
    -> long_hold;
    for (int i = 0; i < BATCH_ITEMS; i++) send_value(random_value());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d character transfers (%0d rejected bases)",
             values_seen, chars_seen, bad_bases);
    $display("over %0d register settings, radix 2 to 40, under three idling patterns.",
             settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* radix_digit_formatter.f */
src/rdf_pkg.sv
src/rdf_in_if.sv
src/rdf_out_if.sv
src/rdf_regs.sv
src/rdf_ctrl.sv
src/rdf_dp.sv
src/radix_digit_formatter.sv
dv/radix_digit_formatter_checker.sv
dv/radix_digit_formatter_tb.sv
